FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module of this project.
// No dependencies; take in by include before any assertion is written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/mtep_pkg.sv
// Types and constants of the MIDI track event parser.
// No dependencies; used by every module of the block.
package mtep_pkg;

  localparam int unsigned MAX_VLQ_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned TICK_W        = 28;

  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE  = 8'hF7;
  localparam logic [7:0] SYSTEM_FIRST  = 8'hF1;
  localparam logic [7:0] SYSTEM_LAST   = 8'hFE;
  localparam logic [3:0] CHANNEL_MASK  = 4'b1111;
  localparam logic [2:0] ONE_DATA_CMDS = 3'b110;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_META    = 2'd1,
    KIND_SYSEX   = 2'd2,
    KIND_ERROR   = 2'd3
  } event_kind_e;

  typedef enum logic [2:0] {
    CLS_DATA,
    CLS_CHAN_STATUS,
    CLS_META,
    CLS_SYSEX,
    CLS_SYSTEM
  } byte_class_e;

  typedef enum logic [8:0] {
    PH_DELTA     = 9'b0_0000_0001,
    PH_STATUS    = 9'b0_0000_0010,
    PH_DATA1     = 9'b0_0000_0100,
    PH_DATA2     = 9'b0_0000_1000,
    PH_META_TYPE = 9'b0_0001_0000,
    PH_META_LEN  = 9'b0_0010_0000,
    PH_META_SKIP = 9'b0_0100_0000,
    PH_SYX_LEN   = 9'b0_1000_0000,
    PH_SYX_SKIP  = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    in_item_t    raw;
    byte_class_e byte_class;
  } class_item_t;

  typedef struct packed {
    event_kind_e         event_kind;
    logic [TICK_W-1:0]   delta_ticks;
    logic [2:0]          command;
    logic [3:0]          channel;
    logic [6:0]          first_data;
    logic [6:0]          second_data;
    logic [7:0]          meta_type;
    logic [TICK_W-1:0]   payload_length;
  } out_item_t;

endpackage

FILE: hdl/mtep_queue.sv
// Small first-in first-out queue of register stages, generic in item type.
// Depends on mtep_pkg for the default depth.
module mtep_queue #(
  parameter int unsigned Depth = mtep_pkg::QUEUE_DEPTH,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/mtep_front.sv
// Front end of the parser: classifies each incoming byte and queues it.
// Depends on mtep_pkg and mtep_queue.
module mtep_front #(
  parameter int unsigned QueueDepth = mtep_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mtep_pkg::in_item_t    in_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output mtep_pkg::class_item_t item_o,
  output logic                  valid_o
);

  mtep_pkg::class_item_t classified;
  logic                  empty;

  always_comb begin
    classified.raw = in_data_i;
    if (!in_data_i.data_byte[7]) begin
      classified.byte_class = mtep_pkg::CLS_DATA;
    end else if (in_data_i.data_byte == mtep_pkg::META_STATUS) begin
      classified.byte_class = mtep_pkg::CLS_META;
    end else if (in_data_i.data_byte inside {mtep_pkg::SYSEX_START, mtep_pkg::SYSEX_ESCAPE}) begin
      classified.byte_class = mtep_pkg::CLS_SYSEX;
    end else if (in_data_i.data_byte inside {[mtep_pkg::SYSTEM_FIRST:mtep_pkg::SYSTEM_LAST]}) begin
      // System common and real-time bytes have no meaning inside a file.
      classified.byte_class = mtep_pkg::CLS_SYSTEM;
    end else begin
      classified.byte_class = mtep_pkg::CLS_CHAN_STATUS;
    end
  end

  mtep_queue #(
    .Depth  (QueueDepth),
    .item_t (mtep_pkg::class_item_t)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (classified),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .item_o  (item_o),
    .empty_o (empty)
  );

  assign valid_o = !empty;

endmodule

FILE: hdl/mtep_parser.sv
// Back end of the parser: the event state machine, one byte per cycle while the result side is not full.
// Depends on mtep_pkg.
module mtep_parser #(
  parameter int unsigned MaxVlqBytes = mtep_pkg::MAX_VLQ_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  mtep_pkg::class_item_t item_i,
  output logic                  take_o,
  input  logic                  out_full_i,
  output logic                  result_valid_o,
  output mtep_pkg::out_item_t   result_o
);

  localparam int unsigned TickW = mtep_pkg::TICK_W;
  localparam int unsigned CntW  = $clog2(MaxVlqBytes + 1);

  mtep_pkg::phase_e  phase_q, phase_d, eff_phase;
  logic [TickW-1:0]  delta_q, delta_d, eff_delta;
  logic [CntW-1:0]   cnt_q, cnt_d, eff_cnt;
  logic [7:0]        rs_q, rs_d, eff_rs;
  logic [6:0]        first_q, first_d, eff_first;
  logic [7:0]        meta_q, meta_d, eff_meta;
  logic [TickW-1:0]  len_q, len_d, eff_len;
  logic [TickW-1:0]  skip_q, skip_d, eff_skip;

  logic [7:0]        b;
  logic              ts;
  logic [TickW-1:0]  vlq_in, vlq_new;
  logic [CntW:0]     cnt_inc;
  logic              vlq_long;
  logic [TickW-1:0]  skip_dec;
  logic              emit;
  mtep_pkg::event_kind_e kind;
  logic [6:0]        second;
  logic [TickW-1:0]  plen;

  assign b      = item_i.raw.data_byte;
  assign ts     = item_i.raw.track_start;
  assign take_o = valid_i && !out_full_i;

  // A track start drops any partial event before the byte is parsed.
  always_comb begin
    eff_phase = ts ? mtep_pkg::PH_DELTA : phase_q;
    eff_delta = ts ? '0 : delta_q;
    eff_cnt   = ts ? '0 : cnt_q;
    eff_rs    = ts ? '0 : rs_q;
    eff_first = ts ? '0 : first_q;
    eff_meta  = ts ? '0 : meta_q;
    eff_len   = ts ? '0 : len_q;
    eff_skip  = ts ? '0 : skip_q;
  end

  assign vlq_in   = (eff_phase == mtep_pkg::PH_DELTA) ? eff_delta : eff_len;
  assign vlq_new  = {vlq_in[TickW-8:0], b[6:0]};
  assign cnt_inc  = {1'b0, eff_cnt} + 1'b1;
  assign vlq_long = b[7] && (cnt_inc >= (CntW+1)'(MaxVlqBytes));
  assign skip_dec = eff_skip - {{(TickW-1){1'b0}}, (eff_skip != '0)};

  always_comb begin
    phase_d = eff_phase;
    delta_d = eff_delta;
    cnt_d   = eff_cnt;
    rs_d    = eff_rs;
    first_d = eff_first;
    meta_d  = eff_meta;
    len_d   = eff_len;
    skip_d  = eff_skip;
    emit    = 1'b0;
    kind    = mtep_pkg::KIND_ERROR;
    second  = '0;
    plen    = '0;

    case (eff_phase)
      mtep_pkg::PH_DELTA: begin
        delta_d = vlq_new;
        cnt_d   = b[7] ? cnt_inc[CntW-1:0] : '0;
        if (vlq_long) begin
          emit = 1'b1;
        end else if (!b[7]) begin
          phase_d = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        case (item_i.byte_class)
          mtep_pkg::CLS_META: begin
            rs_d    = '0;
            phase_d = mtep_pkg::PH_META_TYPE;
          end
          mtep_pkg::CLS_SYSEX: begin
            rs_d    = '0;
            phase_d = mtep_pkg::PH_SYX_LEN;
          end
          mtep_pkg::CLS_CHAN_STATUS: begin
            rs_d    = b;
            phase_d = mtep_pkg::PH_DATA1;
          end
          mtep_pkg::CLS_DATA: begin
            if (eff_rs == '0) begin
              emit = 1'b1;
            end else begin
              first_d = b[6:0];
              if (eff_rs[7:5] == mtep_pkg::ONE_DATA_CMDS) begin
                emit = 1'b1;
                kind = mtep_pkg::KIND_CHANNEL;
              end else begin
                phase_d = mtep_pkg::PH_DATA2;
              end
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      mtep_pkg::PH_DATA1: begin
        if (b[7]) begin
          emit = 1'b1;
        end else begin
          first_d = b[6:0];
          if (eff_rs[7:5] == mtep_pkg::ONE_DATA_CMDS) begin
            emit = 1'b1;
            kind = mtep_pkg::KIND_CHANNEL;
          end else begin
            phase_d = mtep_pkg::PH_DATA2;
          end
        end
      end
      mtep_pkg::PH_DATA2: begin
        emit = 1'b1;
        if (!b[7]) begin
          kind   = mtep_pkg::KIND_CHANNEL;
          second = b[6:0];
        end
      end
      mtep_pkg::PH_META_TYPE: begin
        meta_d  = b;
        phase_d = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYX_LEN: begin
        len_d = vlq_new;
        cnt_d = b[7] ? cnt_inc[CntW-1:0] : '0;
        if (vlq_long) begin
          emit = 1'b1;
        end else if (!b[7]) begin
          if (vlq_new == '0) begin
            // An empty payload reports on its last length byte.
            emit = 1'b1;
            kind = (eff_phase == mtep_pkg::PH_META_LEN) ? mtep_pkg::KIND_META
                                                         : mtep_pkg::KIND_SYSEX;
          end else begin
            skip_d  = vlq_new;
            phase_d = (eff_phase == mtep_pkg::PH_META_LEN) ? mtep_pkg::PH_META_SKIP
                                                            : mtep_pkg::PH_SYX_SKIP;
          end
        end
      end
      mtep_pkg::PH_META_SKIP, mtep_pkg::PH_SYX_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          emit = 1'b1;
          kind = (eff_phase == mtep_pkg::PH_META_SKIP) ? mtep_pkg::KIND_META
                                                        : mtep_pkg::KIND_SYSEX;
          plen = eff_len;
        end
      end
      default: begin
        phase_d = mtep_pkg::PH_DELTA;
        delta_d = '0;
        cnt_d   = '0;
        first_d = '0;
        meta_d  = '0;
        len_d   = '0;
        skip_d  = '0;
      end
    endcase

    // The report sees the state as updated by this byte.
    result_o.event_kind     = kind;
    result_o.delta_ticks    = delta_d;
    result_o.command        = (kind == mtep_pkg::KIND_CHANNEL) ? rs_d[6:4] : '0;
    result_o.channel        = (kind == mtep_pkg::KIND_CHANNEL)
                              ? (rs_d[3:0] & mtep_pkg::CHANNEL_MASK) : '0;
    result_o.first_data     = (kind == mtep_pkg::KIND_CHANNEL) ? first_d : '0;
    result_o.second_data    = second;
    result_o.meta_type      = (kind == mtep_pkg::KIND_META) ? meta_d : '0;
    result_o.payload_length = plen;

    if (emit) begin
      phase_d = mtep_pkg::PH_DELTA;
      delta_d = '0;
      cnt_d   = '0;
      first_d = '0;
      meta_d  = '0;
      len_d   = '0;
      skip_d  = '0;
    end
  end

  assign result_valid_o = take_o && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mtep_pkg::PH_DELTA;
      delta_q <= '0;
      cnt_q   <= '0;
      rs_q    <= '0;
      first_q <= '0;
      meta_q  <= '0;
      len_q   <= '0;
      skip_q  <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      delta_q <= delta_d;
      cnt_q   <= cnt_d;
      rs_q    <= rs_d;
      first_q <= first_d;
      meta_q  <= meta_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
    end
  end

endmodule

FILE: hdl/midi_track_event_parser.sv
// The parser takes the body of a MIDI track chunk one byte per transaction and
// gives one result per completed event (channel message, meta event or sysex
// event) or one error result per malformed event. It accepts a byte every clock
// cycle as long as results are taken; the state machine in the parser handles
// one byte per cycle while the result queue is not full. A byte that ends an
// event is registered in the input queue; the parser forms its result, which is
// registered in the result queue and then shown on the result ports. Two-entry
// queues on the input and the result side absorb a brief stall of either side.
//
// Top level of the MIDI track event parser.
// Depends on mtep_pkg, mtep_front, mtep_parser and mtep_queue.
module midi_track_event_parser #(
  parameter int unsigned MaxVlqBytes = mtep_pkg::MAX_VLQ_BYTES,
  parameter int unsigned QueueDepth  = mtep_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  mtep_pkg::in_item_t  in_data_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output mtep_pkg::out_item_t out_data_o
);

  mtep_pkg::class_item_t byte_item;
  logic                  byte_valid;
  logic                  byte_take;
  logic                  res_full;
  logic                  res_valid;
  mtep_pkg::out_item_t   res_item;

  mtep_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .full_o    (full),
    .pop_i     (byte_take),
    .item_o    (byte_item),
    .valid_o   (byte_valid)
  );

  mtep_parser #(
    .MaxVlqBytes (MaxVlqBytes)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (byte_valid),
    .item_i         (byte_item),
    .take_o         (byte_take),
    .out_full_i     (res_full),
    .result_valid_o (res_valid),
    .result_o       (res_item)
  );

  mtep_queue #(
    .Depth  (QueueDepth),
    .item_t (mtep_pkg::out_item_t)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .item_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .item_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

FILE: hdl/mtep_checker.sv
// Port-level checks of the MIDI track event parser, bound to the top level.
// Depends on mtep_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtep_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input mtep_pkg::out_item_t out_data_o
);

  logic shown;
  logic chan_zero;
  logic not_chan;
  logic not_meta;
  logic no_plen_kind;

  assign shown     = !empty;
  assign chan_zero = (out_data_o.command == '0) && (out_data_o.channel == '0)
                     && (out_data_o.first_data == '0) && (out_data_o.second_data == '0);
  assign not_chan     = shown && (out_data_o.event_kind != mtep_pkg::KIND_CHANNEL);
  assign not_meta     = shown && (out_data_o.event_kind != mtep_pkg::KIND_META);
  assign no_plen_kind = shown && ((out_data_o.event_kind == mtep_pkg::KIND_CHANNEL)
                                  || (out_data_o.event_kind == mtep_pkg::KIND_ERROR));

  // Channel fields are only filled in for channel messages.
  `ASSERT_IMPLY(a_chan_fields, clk_i, rst_ni, not_chan, chan_zero)

  // Only meta events carry a type byte.
  `ASSERT_IMPLY(a_meta_type, clk_i, rst_ni, not_meta, out_data_o.meta_type == '0)

  // Channel messages and errors declare no payload.
  `ASSERT_IMPLY(a_no_payload, clk_i, rst_ni, no_plen_kind, out_data_o.payload_length == '0)

  // A result that is not popped stays on the ports unchanged.
  `ASSERT_NEXT(a_hold_result, clk_i, rst_ni, shown && !pop, !empty && $stable(out_data_o))

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);

FILE: sim/midi_track_event_checker.sv
// Checker for the MIDI track event parser: predicts the event results of every
// accepted byte and compares them, field by field, with the popped results.
// Depends on mtep_pkg only; instantiated beside the parser by the testbench top.
module midi_track_event_checker
  import mtep_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_data_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_data_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned channel_seen_o,
  output int unsigned meta_seen_o,
  output int unsigned sysex_seen_o,
  output int unsigned error_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    VLQ_MORE,
    VLQ_DONE,
    VLQ_TOO_LONG
  } vlq_step_e;

  // Parser state as seen from the byte stream.
  phase_e            parse_phase;
  logic [TICK_W-1:0] delta_acc;
  logic [2:0]        vlq_count;
  logic [7:0]        run_status;
  logic [6:0]        held_first;
  logic [7:0]        held_meta;
  logic [TICK_W-1:0] length_acc;
  logic [TICK_W-1:0] skip_left;

  out_item_t   expected_events[$];
  int unsigned mismatch_count = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic restart_event();
    parse_phase = PH_DELTA;
    delta_acc   = '0;
    vlq_count   = '0;
    held_first  = '0;
    held_meta   = '0;
    length_acc  = '0;
    skip_left   = '0;
  endtask

  task automatic close_event(input event_kind_e kind, input logic [6:0] second_byte,
                             input logic [TICK_W-1:0] plen);
    out_item_t ev;
    ev = '0;
    ev.event_kind  = kind;
    ev.delta_ticks = delta_acc;
    if (kind == KIND_CHANNEL) begin
      ev.command     = run_status[6:4];
      ev.channel     = run_status[3:0];
      ev.first_data  = held_first;
      ev.second_data = second_byte;
    end
    if (kind == KIND_META) begin
      ev.meta_type = held_meta;
    end
    if (kind == KIND_META || kind == KIND_SYSEX) begin
      ev.payload_length = plen;
    end
    expected_events.push_back(ev);
    restart_event();
  endtask

  // Shifts one 7-bit group into a variable-length quantity.
  task automatic add_vlq_byte(inout logic [TICK_W-1:0] acc, input logic [7:0] b,
                              output vlq_step_e step);
    acc       = {acc[TICK_W-8:0], b[6:0]};
    vlq_count = vlq_count + 3'd1;
    if (!b[7]) begin
      vlq_count = '0;
      step      = VLQ_DONE;
    end else if (vlq_count >= MAX_VLQ_BYTES) begin
      step = VLQ_TOO_LONG;
    end else begin
      step = VLQ_MORE;
    end
  endtask

  task automatic take_first_data(input logic [6:0] d);
    held_first = d;
    if (run_status[7:5] == ONE_DATA_CMDS) begin
      close_event(KIND_CHANNEL, '0, '0);
    end else begin
      parse_phase = PH_DATA2;
    end
  endtask

  task automatic decode_track_byte(input in_item_t item);
    logic [7:0]  b;
    vlq_step_e   step;
    event_kind_e kind;
    b = item.data_byte;
    if (item.track_start) begin
      restart_event();
      run_status = '0;
    end
    case (parse_phase)
      PH_DELTA: begin
        add_vlq_byte(delta_acc, b, step);
        if (step == VLQ_TOO_LONG) begin
          close_event(KIND_ERROR, '0, '0);
        end else if (step == VLQ_DONE) begin
          parse_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == META_STATUS) begin
          run_status  = '0;
          parse_phase = PH_META_TYPE;
        end else if (b == SYSEX_START || b == SYSEX_ESCAPE) begin
          run_status  = '0;
          parse_phase = PH_SYX_LEN;
        end else if (b >= SYSTEM_FIRST) begin
          close_event(KIND_ERROR, '0, '0);
        end else if (b[7]) begin
          run_status  = b;
          parse_phase = PH_DATA1;
        end else if (run_status == '0) begin
          close_event(KIND_ERROR, '0, '0);
        end else begin
          take_first_data(b[6:0]);
        end
      end
      PH_DATA1: begin
        if (b[7]) begin
          close_event(KIND_ERROR, '0, '0);
        end else begin
          take_first_data(b[6:0]);
        end
      end
      PH_DATA2: begin
        if (b[7]) begin
          close_event(KIND_ERROR, '0, '0);
        end else begin
          close_event(KIND_CHANNEL, b[6:0], '0);
        end
      end
      PH_META_TYPE: begin
        held_meta   = b;
        parse_phase = PH_META_LEN;
      end
      PH_META_LEN, PH_SYX_LEN: begin
        kind = (parse_phase == PH_META_LEN) ? KIND_META : KIND_SYSEX;
        add_vlq_byte(length_acc, b, step);
        if (step == VLQ_TOO_LONG) begin
          close_event(KIND_ERROR, '0, '0);
        end else if (step == VLQ_DONE) begin
          if (length_acc == '0) begin
            close_event(kind, '0, '0);
          end else begin
            skip_left   = length_acc;
            parse_phase = (kind == KIND_META) ? PH_META_SKIP : PH_SYX_SKIP;
          end
        end
      end
      PH_META_SKIP, PH_SYX_SKIP: begin
        kind = (parse_phase == PH_META_SKIP) ? KIND_META : KIND_SYSEX;
        if (skip_left != '0) begin
          skip_left = skip_left - 1'b1;
        end
        if (skip_left == '0) begin
          close_event(kind, '0, length_acc);
        end
      end
      default: begin
        restart_event();
      end
    endcase
  endtask

  task automatic compare_event(input out_item_t got, input out_item_t want);
    if (got.event_kind !== want.event_kind) begin
      report_mismatch($sformatf("event_kind got %0d want %0d", got.event_kind,
                                want.event_kind));
    end
    if (got.delta_ticks !== want.delta_ticks) begin
      report_mismatch($sformatf("delta_ticks got %0h want %0h", got.delta_ticks,
                                want.delta_ticks));
    end
    if (got.command !== want.command) begin
      report_mismatch($sformatf("command got %0d want %0d", got.command, want.command));
    end
    if (got.channel !== want.channel) begin
      report_mismatch($sformatf("channel got %0d want %0d", got.channel, want.channel));
    end
    if (got.first_data !== want.first_data) begin
      report_mismatch($sformatf("first_data got %0h want %0h", got.first_data,
                                want.first_data));
    end
    if (got.second_data !== want.second_data) begin
      report_mismatch($sformatf("second_data got %0h want %0h", got.second_data,
                                want.second_data));
    end
    if (got.meta_type !== want.meta_type) begin
      report_mismatch($sformatf("meta_type got %0h want %0h", got.meta_type,
                                want.meta_type));
    end
    if (got.payload_length !== want.payload_length) begin
      report_mismatch($sformatf("payload_length got %0h want %0h", got.payload_length,
                                want.payload_length));
    end
  endtask

  // Outputs are updated with nonblocking assignments so that the top always
  // reads the totals as they stood before the current edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_event();
      run_status = '0;
      expected_events.delete();
      mismatches_o   <= 0;
      pending_o      <= 0;
      channel_seen_o <= 0;
      meta_seen_o    <= 0;
      sysex_seen_o   <= 0;
      error_seen_o   <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with no event pending",
                                    out_data_i.event_kind));
        end else begin
          compare_event(out_data_i, expected_events.pop_front());
        end
        kind_seen[out_data_i.event_kind]++;
      end
      if (push_i && !full_i) begin
        decode_track_byte(in_data_i);
      end
      mismatches_o   <= mismatch_count;
      pending_o      <= expected_events.size();
      channel_seen_o <= kind_seen[KIND_CHANNEL];
      meta_seen_o    <= kind_seen[KIND_META];
      sysex_seen_o   <= kind_seen[KIND_SYSEX];
      error_seen_o   <= kind_seen[KIND_ERROR];
    end
  end

endmodule

FILE: sim/midi_track_event_parser_tb.sv
// Testbench top of the MIDI track event parser: drives track bytes and result
// pops, and gives the verdict. Depends on mtep_pkg, the parser and
// midi_track_event_checker, which does all prediction and comparison.
module midi_track_event_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtep_pkg::*;

  localparam int unsigned RANDOM_BYTES      = 2000;
  localparam int unsigned LONG_HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_TAIL_CYCLES = 20;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  logic      empty;
  logic      pop = 1'b0;
  in_item_t  in_data;
  out_item_t out_data;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned channel_seen;
  int unsigned meta_seen;
  int unsigned sysex_seen;
  int unsigned error_seen;

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned hold_left = 0;

  int unsigned bytes_sent    = 0;
  logic        have_status   = 1'b0;
  logic [7:0]  last_status   = '0;
  logic        restart_track = 1'b0;

  midi_track_event_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .in_data_i  (in_data),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  midi_track_event_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push_i         (push),
    .full_i         (full),
    .in_data_i      (in_data),
    .empty_i        (empty),
    .pop_i          (pop),
    .out_data_i     (out_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .channel_seen_o (channel_seen),
    .meta_seen_o    (meta_seen),
    .sysex_seen_o   (sysex_seen),
    .error_seen_o   (error_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random pops, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ts = 1'b0);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= '{data_byte: b, track_start: ts};
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_delta();
    int unsigned pick;
    int unsigned groups;
    logic        ts;
    pick   = $urandom_range(99);
    groups = (pick < 70) ? 1 : (pick < 85) ? 2 : (pick < 93) ? 3 : 4;
    ts     = restart_track || ($urandom_range(99) < 3);
    if (ts) begin
      have_status = 1'b0;
    end
    restart_track = 1'b0;
    for (int i = 0; i < groups; i++) begin
      send_byte({i != groups - 1, 7'($urandom)}, ts && i == 0);
    end
  endtask

  task automatic send_length_and_payload(input int unsigned len);
    if (len < 128) begin
      send_byte(8'(len));
    end else begin
      send_byte({1'b1, 7'(len >> 7)});
      send_byte({1'b0, 7'(len)});
    end
    repeat (len) send_byte(8'($urandom));
  endtask

  function automatic int unsigned pick_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(4);
    if (pick < 90) return $urandom_range(20, 5);
    return $urandom_range(300, 120);
  endfunction

  task automatic send_channel_event(input logic running);
    if (!running || !have_status) begin
      last_status = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
      have_status = 1'b1;
      send_byte(last_status);
    end
    send_byte({1'b0, 7'($urandom)});
    if (last_status[7:5] != ONE_DATA_CMDS) begin
      send_byte({1'b0, 7'($urandom)});
    end
  endtask

  task automatic send_random_event();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick >= 94) begin
      // A delta time that still has its continuation bit set on the last group.
      repeat (MAX_VLQ_BYTES) send_byte({1'b1, 7'($urandom)});
      return;
    end
    send_delta();
    if (pick < 55) begin
      send_channel_event($urandom_range(1));
    end else if (pick < 66) begin
      have_status = 1'b0;
      send_byte(META_STATUS);
      send_byte(8'($urandom));
      send_length_and_payload(pick_length());
    end else if (pick < 76) begin
      have_status = 1'b0;
      send_byte($urandom_range(1) ? SYSEX_START : SYSEX_ESCAPE);
      send_length_and_payload(pick_length());
    end else begin
      case ($urandom_range(5))
        0: send_byte(8'($urandom));
        1: send_byte(8'($urandom_range(SYSTEM_LAST, SYSTEM_FIRST)));
        2: begin
          last_status = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
          have_status = 1'b1;
          send_byte(last_status);
          send_byte({1'b1, 7'($urandom)});
        end
        3: begin
          have_status = 1'b0;
          send_byte(META_STATUS);
          send_byte(8'($urandom));
          repeat (MAX_VLQ_BYTES) send_byte({1'b1, 7'($urandom)});
        end
        4: begin
          // Largest declared length; the payload is cut off by a new track.
          send_byte(META_STATUS);
          send_byte(8'($urandom));
          send_byte(8'hFF);
          send_byte(8'hFF);
          send_byte(8'hFF);
          send_byte(8'h7F);
          repeat ($urandom_range(5)) send_byte(8'($urandom));
          restart_track = 1'b1;
        end
        default: begin
          send_byte({1'b1, 3'($urandom_range(6)), 4'($urandom)});
          restart_track = 1'b1;
        end
      endcase
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct   = 21;
    receiver_idle_pct <= 76;

    // Note on, then a second note-on message under running status.
    send_byte(8'h00, 1'b1); send_byte(8'h90); send_byte(8'h3C); send_byte(8'h7F);
    send_byte(8'h00); send_byte(8'h40); send_byte(8'h00);
    // Largest delta time, then a program change with its single data byte.
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'hCF); send_byte(8'h00);
    // Meta event with an empty payload; it also cancels running status.
    send_byte(8'h00); send_byte(META_STATUS); send_byte(8'h2F); send_byte(8'h00);
    // Data byte while no running status is held.
    send_byte(8'h00); send_byte(8'h40);
    // Delta time one group too long.
    send_byte(8'h80); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
    // Sysex escape with a two-byte payload.
    send_byte(8'h00); send_byte(SYSEX_ESCAPE); send_byte(8'h02); send_byte(8'hAA);
    send_byte(8'h55);
    // System byte in a file, then a status byte where data was due.
    send_byte(8'h00); send_byte(SYSTEM_LAST);
    send_byte(8'h00); send_byte(8'hE0); send_byte(8'h12); send_byte(8'h90);
    have_status = 1'b0;

    for (int mode = 0; mode < 3; mode++) begin
      wait_results_drained();
      sender_idle_pct   = (mode == 0) ? 21 : (mode == 1) ? 76 : 0;
      receiver_idle_pct <= (mode == 0) ? 76 : (mode == 1) ? 21 : 0;
      if (mode == 2) begin
        // The result side stalls while channel messages keep coming, so the
        // parser backs up and holds off the input.
        hold_req <= ~hold_req;
        repeat (25) begin
          send_delta();
          send_channel_event(1'b0);
        end
      end
      while (bytes_sent < 34 + (mode + 1) * RANDOM_BYTES / 3) begin
        send_random_event();
      end
    end

    wait_results_drained();
    repeat (DRAIN_TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d track bytes pushed; results checked: %0d channel, %0d meta,",
             bytes_sent, channel_seen, meta_seen);
    $display("  %0d sysex, %0d error, including running status, track restarts and stalls.",
             sysex_seen, error_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("[midi_track_event_parser] OK");
    end else begin
      $display("[midi_track_event_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", pending);
    $display("[midi_track_event_parser] ERROR");
    $finish;
  end

endmodule
